[design/cor_pkg.sv]
// shared types, constants and sine table function for the carrier offset rotator
package cor_pkg;

    // default widths
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_STEP     = 3'd0,
        REG_PHASE_OFFSET  = 3'd1,
        REG_JITTER_STEP   = 3'd2,
        REG_JITTER_AMP    = 3'd3,
        REG_JITTER_ENABLE = 3'd4
    } cfg_reg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_COS,
        ST_RD_JIT,
        ST_MUL,
        ST_SUM
    } cor_state_t;

    // which phase addresses the sine table
    typedef enum logic [1:0] {
        SEL_SIN_HELD,
        SEL_COS_HELD,
        SEL_SIN_JIT
    } rd_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    latch_s;
        logic    latch_c;
        logic    multiply;
        logic    commit;
    } cor_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } cor_stat_t;

    // quarter-wave sine entry k, evaluated at elaboration by a Q30 Taylor polynomial
    function automatic longint unsigned quarter_rom(input longint unsigned k_in,
                                                   input int tab_bits,
                                                   input int sample_bits);
        longint unsigned one;
        longint unsigned full;
        longint unsigned n_top;
        longint unsigned k;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        one   = 64'd1 << 30;
        full  = (64'd1 << (sample_bits - 1)) - 64'd1;
        n_top = 64'd1 << tab_bits;
        k     = (k_in > n_top) ? n_top : k_in;
        y     = (k * HALF_PI_Q30) >> tab_bits;
        y2    = (y * y) >> 30;
        t     = one;
        t     = one - ((y2 * t) >> 30) / 64'd156;
        t     = one - ((y2 * t) >> 30) / 64'd110;
        t     = one - ((y2 * t) >> 30) / 64'd72;
        t     = one - ((y2 * t) >> 30) / 64'd42;
        t     = one - ((y2 * t) >> 30) / 64'd20;
        t     = one - ((y2 * t) >> 30) / 64'd6;
        s     = (y * t) >> 30;
        if (s > one)
            s = one;
        q = (s * full + (one >> 1)) >> 30;
        if (q > full)
            q = full;
        return q;
    endfunction

endpackage

[design/carrier_offset_rotator.sv]
// Carrier offset rotator: rotates each complex sample by the phase held from the
// previous word, then latches the next phase (carrier accumulator plus offset, or
// amplitude times the sine of the jitter accumulator). Each word is processed by three
// successive reads of a single registered quarter-wave sine table (sine of the held
// phase while waiting for the word, cosine of the held phase, sine of the jitter
// phase), a multiply stage and a round and saturate stage; the result then enters the
// output register, and the input reopens as the result appears there. A new word is
// accepted while the previous result still waits in the output register, and the
// sequence stretches only while that register is stalled.
module carrier_offset_rotator
    import cor_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_i,
    output logic signed [SAMPLE_BITS-1:0] out_q
);

    cor_cmd_t  cmd;
    cor_stat_t stat;

    // sequencer
    cor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    cor_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q)
    );

endmodule

[design/cor_ctrl.sv]
// sequencing controller for the carrier offset rotator
module cor_ctrl
    import cor_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  cor_stat_t stat,
    output cor_cmd_t  cmd
);

    cor_state_t state_reg;
    cor_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = SEL_SIN_HELD;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                // sine of the held phase is read while waiting for a word
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_RD_COS;
            end
            ST_RD_COS:
            begin
                cmd.rd_sel  = SEL_COS_HELD;
                cmd.latch_s = 1'b1;
                state_next  = ST_RD_JIT;
            end
            ST_RD_JIT:
            begin
                cmd.rd_sel  = SEL_SIN_JIT;
                cmd.latch_c = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                // wait here until the output register can take the word
                cmd.commit = stat.out_free;
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/cor_datapath.sv]
// datapath: config registers, phase state, sine table, multipliers and output register
module cor_datapath
    import cor_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    input  cor_cmd_t                      cmd,
    output cor_stat_t                     stat,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_i,
    output logic signed [SAMPLE_BITS-1:0] out_q
);

    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int ADDR_W = TABLE_ADDR_BITS + 1;
    localparam int TAB_N  = 1 << TABLE_ADDR_BITS;
    localparam int AMP_W  = (PHASE_BITS < CFG_W) ? PHASE_BITS : CFG_W;
    localparam int JP_W   = AMP_W + MAG_W + 1;
    localparam int JR_W   = JP_W - FRAC;
    localparam int ACC_W  = 2 * SAMPLE_BITS + 1;
    localparam int RW     = ACC_W - FRAC;

    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};
    localparam logic [JP_W-1:0]       JRND    = JP_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [RW-1:0]  S_MAX   = RW'((1 << FRAC) - 1);
    localparam logic signed [RW-1:0]  S_MIN   = -RW'(1 << FRAC);

    // configuration registers
    logic [CFG_W-1:0] freq_step_reg;
    logic [CFG_W-1:0] phase_offset_reg;
    logic [CFG_W-1:0] jitter_step_reg;
    logic [CFG_W-1:0] jitter_amp_reg;
    logic             jitter_enable_reg;

    // phase state
    logic [PHASE_BITS-1:0] carrier_acc_reg;
    logic [PHASE_BITS-1:0] jitter_acc_reg;
    logic [PHASE_BITS-1:0] held_phase_reg;
    logic [PHASE_BITS-1:0] held_phase_next;

    // sample and trig operands
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] sin_reg;
    logic signed [SAMPLE_BITS-1:0] cos_reg;

    // sine table
    logic [MAG_W-1:0]      rom_table [0:TAB_N];
    logic [PHASE_BITS-1:0] rd_phase;
    logic [1:0]            rd_quad;
    logic [ADDR_W-1:0]     rd_idx;
    logic [ADDR_W-1:0]     rom_addr;
    logic [MAG_W-1:0]      rom_mag_reg;
    logic                  rom_neg_reg;
    logic [SAMPLE_BITS-1:0] mag_ext;
    logic signed [SAMPLE_BITS-1:0] trig_val;

    // products
    logic signed [2*SAMPLE_BITS-1:0] prod_xc_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_ys_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_xs_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_yc_reg;
    logic [JP_W-1:0]                 jit_prod_reg;
    logic                            jit_neg_reg;

    // final sums
    logic signed [ACC_W-1:0]       sum_i;
    logic signed [ACC_W-1:0]       sum_q;
    logic [JR_W-1:0]               jit_round;
    logic [PHASE_BITS-1:0]         jit_phase;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_i_reg;
    logic signed [SAMPLE_BITS-1:0] out_q_reg;

    // round half up by the fraction width, then saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] b;
        logic signed [RW-1:0]    r;
        b = v + RND;
        r = RW'(b >>> FRAC);
        if (r > S_MAX)
            r = S_MAX;
        else if (r < S_MIN)
            r = S_MIN;
        return SAMPLE_BITS'(r);
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg     <= '0;
            phase_offset_reg  <= '0;
            jitter_step_reg   <= '0;
            jitter_amp_reg    <= '0;
            jitter_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FREQ_STEP:     freq_step_reg     <= cfg_data;
                REG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data;
                REG_JITTER_STEP:   jitter_step_reg   <= cfg_data;
                REG_JITTER_AMP:    jitter_amp_reg    <= cfg_data;
                REG_JITTER_ENABLE: jitter_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // quarter-wave table, constant entries
    for (genvar gk = 0; gk <= TAB_N; gk++)
    begin : g_rom
        assign rom_table[gk] = MAG_W'(quarter_rom(64'(gk), TABLE_ADDR_BITS, SAMPLE_BITS));
    end

    // table address from the selected phase, mirrored in odd quadrants
    always_comb
    begin
        unique case (cmd.rd_sel)
            SEL_SIN_HELD: rd_phase = held_phase_reg;
            SEL_COS_HELD: rd_phase = held_phase_reg + QUARTER;
            SEL_SIN_JIT:  rd_phase = jitter_acc_reg;
            default:      rd_phase = held_phase_reg;
        endcase
        rd_quad  = rd_phase[PHASE_BITS-1 -: 2];
        rd_idx   = {1'b0, rd_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
        rom_addr = rd_quad[0] ? (ADDR_W'(TAB_N) - rd_idx) : rd_idx;
    end

    // registered table read, sign follows the lower half-turn
    always_ff @(posedge clk)
    begin
        rom_mag_reg <= rom_table[rom_addr];
        rom_neg_reg <= rd_quad[1];
    end

    assign mag_ext  = {1'b0, rom_mag_reg};
    assign trig_val = rom_neg_reg ? -$signed(mag_ext) : $signed(mag_ext);

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= sample_i;
            y_reg <= sample_q;
        end
        if (cmd.latch_s)
            sin_reg <= trig_val;
        if (cmd.latch_c)
            cos_reg <= trig_val;
    end

    // multiplier stage
    always_ff @(posedge clk)
    begin
        if (cmd.multiply)
        begin
            prod_xc_reg  <= x_reg * cos_reg;
            prod_ys_reg  <= y_reg * sin_reg;
            prod_xs_reg  <= x_reg * sin_reg;
            prod_yc_reg  <= y_reg * cos_reg;
            jit_prod_reg <= JP_W'(jitter_amp_reg[AMP_W-1:0]) * JP_W'(rom_mag_reg);
            jit_neg_reg  <= rom_neg_reg;
        end
    end

    // rotation sums and next phase
    always_comb
    begin
        sum_i     = ACC_W'(prod_xc_reg) - ACC_W'(prod_ys_reg);
        sum_q     = ACC_W'(prod_xs_reg) + ACC_W'(prod_yc_reg);
        jit_round = JR_W'((jit_prod_reg + JRND) >> FRAC);
        jit_phase = PHASE_BITS'(jit_round);
        if (jitter_enable_reg)
            held_phase_next = jit_neg_reg ? (PHASE_BITS'(0) - jit_phase) : jit_phase;
        else
            held_phase_next = carrier_acc_reg + PHASE_BITS'(phase_offset_reg);
    end

    // phase state advances once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_acc_reg <= '0;
            jitter_acc_reg  <= '0;
            held_phase_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            held_phase_reg  <= held_phase_next;
            carrier_acc_reg <= carrier_acc_reg + PHASE_BITS'(freq_step_reg);
            jitter_acc_reg  <= jitter_acc_reg + PHASE_BITS'(jitter_step_reg);
        end
    end

    // output register
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_i_reg <= round_sat(sum_i);
            out_q_reg <= round_sat(sum_q);
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_i         = out_i_reg;
    assign out_q         = out_q_reg;

endmodule

[design/cor_checker.sv]
// port-level checks for the carrier offset rotator and their binding
module cor_checker
    import cor_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] out_i,
    input logic signed [SAMPLE_BITS-1:0] out_q
);

    // a stalled result word stays and holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q))
        else $error("stalled output word changed");

    // an accepted word keeps the input busy for the whole computation
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
        else $error("input released before the word finished");

    // a new result only appears at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a word in progress");

    // the input reopens only once the result sits in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input reopened without a result word");

endmodule

bind carrier_offset_rotator cor_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cor_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q)
);

[bench/testbench.sv]
// self-checking regression bench for the carrier offset rotator
module testbench;
    import cor_pkg::*;

    localparam int PH_W  = PHASE_BITS_DEF;
    localparam int SMP_W = SAMPLE_BITS_DEF;
    localparam int TAB_W = TABLE_ADDR_BITS_DEF;
    localparam int FRAC  = SMP_W - 1;
    localparam int TAB_N = 1 << TAB_W;

    localparam longint SMP_MAX = (longint'(1) << FRAC) - 1;
    localparam longint SMP_MIN = -(longint'(1) << FRAC);
    localparam logic signed [SMP_W-1:0] FULL_POS = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] FULL_NEG = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [PH_W-1:0] QUARTER_TURN = {2'b01, {(PH_W-2){1'b0}}};

    localparam longint unsigned Q30_ONE         = 64'd1 << 30;
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int PAT_W        = 11;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_MARGIN = 16;
    localparam int PRINT_CAP    = 50;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_PATTERN,
        SINK_RANDOM,
        SINK_HOLD
    } sink_mode_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
    } iq_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [SMP_W-1:0] sample_i  = '0;
    logic signed [SMP_W-1:0] sample_q  = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [SMP_W-1:0] out_i;
    logic signed [SMP_W-1:0] out_q;

    carrier_offset_rotator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q)
    );

    always #10 clk = ~clk;

    // rotator model: register copies, accumulators and the held phase
    logic [PH_W-1:0] freq_step_m;
    logic [PH_W-1:0] phase_offset_m;
    logic [PH_W-1:0] jitter_step_m;
    logic [PH_W-1:0] jitter_amp_m;
    logic            jitter_on_m;
    logic [PH_W-1:0] carrier_phase_m;
    logic [PH_W-1:0] jitter_phase_m;
    logic [PH_W-1:0] held_phase_m;
    int              sine_rom [0:TAB_N];

    iq_t        pending_iq [$];
    iq_t        oldest_iq;
    int         words_sent     = 0;
    int         results_seen   = 0;
    int         mismatch_count = 0;
    int         burst_left     = 0;
    bit         src_gaps       = 1'b0;
    sink_mode_t sink_mode      = SINK_OPEN;
    logic [PAT_W-1:0] stall_pattern = 11'b01100010110;
    int         hold_count     = 0;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch: %s", msg);
    endtask

    // quarter-wave sine entry k from a Q30 Taylor series, scaled to full scale
    function automatic int taylor_sine(input int k);
        longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned full;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        full = (64'd1 << FRAC) - 1;
        y    = (longint'(k) * RIGHT_ANGLE_Q30) >> TAB_W;
        y2   = (y * y) >> 30;
        t    = Q30_ONE;
        for (int n = 0; n < 6; n++)
            t = Q30_ONE - ((y2 * t) >> 30) / divs[n];
        s = (y * t) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        q = (s * full + (Q30_ONE >> 1)) >> 30;
        if (q > full)
            q = full;
        return int'(q);
    endfunction

    // quadrant folding of the quarter-wave table, no interpolation
    function automatic int sine_lookup(input logic [PH_W-1:0] p);
        logic [1:0] quad;
        int         k;
        int         mag;
        quad = p[PH_W-1 -: 2];
        k    = int'(p[PH_W-3 -: TAB_W]);
        if (quad[0])
            k = TAB_N - k;
        mag = sine_rom[k];
        return quad[1] ? -mag : mag;
    endfunction

    // round half up by the fraction width, then clamp to the sample range
    function automatic logic signed [SMP_W-1:0] round_saturate(input longint acc);
        longint r;
        r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (r > SMP_MAX)
            r = SMP_MAX;
        if (r < SMP_MIN)
            r = SMP_MIN;
        return r[SMP_W-1:0];
    endfunction

    // rotate by the held phase, queue the result, then latch the next phase
    task automatic advance_rotator_model(input logic signed [SMP_W-1:0] si,
                                         input logic signed [SMP_W-1:0] sq);
        longint          x;
        longint          y;
        longint          c;
        longint          s;
        int              js;
        longint unsigned amp64;
        longint unsigned mag64;
        longint unsigned prod;
        longint unsigned wide;
        iq_t             want;
        x = si;
        y = sq;
        c = sine_lookup(held_phase_m + QUARTER_TURN);
        s = sine_lookup(held_phase_m);
        want.i = round_saturate(x * c - y * s);
        want.q = round_saturate(x * s + y * c);
        pending_iq.push_back(want);

        if (jitter_on_m) begin
            js    = sine_lookup(jitter_phase_m);
            amp64 = jitter_amp_m;
            mag64 = (js < 0) ? longint'(-js) : longint'(js);
            prod  = (amp64 * mag64 + (64'd1 << (FRAC - 1))) >> FRAC;
            wide  = (js < 0) ? (64'd0 - prod) : prod;
            held_phase_m = wide[PH_W-1:0];
        end else begin
            held_phase_m = carrier_phase_m + phase_offset_m;
        end
        carrier_phase_m = carrier_phase_m + freq_step_m;
        jitter_phase_m  = jitter_phase_m + jitter_step_m;
    endtask

    // one register write; the caller lowers the write enable after a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FREQ_STEP:     freq_step_m    = data;
            REG_PHASE_OFFSET:  phase_offset_m = data;
            REG_JITTER_STEP:   jitter_step_m  = data;
            REG_JITTER_AMP:    jitter_amp_m   = data;
            REG_JITTER_ENABLE: jitter_on_m    = data[0];
            default: ;
        endcase
    endtask

    task automatic program_rotator(input logic [CFG_W-1:0] freq, input logic [CFG_W-1:0] offset,
                                   input logic [CFG_W-1:0] jstep, input logic [CFG_W-1:0] amp,
                                   input logic [CFG_W-1:0] enable);
        write_reg(REG_FREQ_STEP, freq);
        write_reg(REG_PHASE_OFFSET, offset);
        write_reg(REG_JITTER_STEP, jstep);
        write_reg(REG_JITTER_AMP, amp);
        write_reg(REG_JITTER_ENABLE, enable);
        cfg_we <= 1'b0;
    endtask

    // offer one word and hold it until the block takes it
    task automatic send_word(input logic signed [SMP_W-1:0] si,
                             input logic signed [SMP_W-1:0] sq);
        in_valid <= 1'b1;
        sample_i <= si;
        sample_q <= sq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_rotator_model(si, sq);
        words_sent++;
    endtask

    // sender pauses until every queued result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (results_seen < words_sent)
            @(posedge clk);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
            1: return SMP_W'($urandom_range(0, 15)) - SMP_W'(8);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_phase_reg();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(0, 4095));
            3: return {2'($urandom_range(0, 3)), {(CFG_W-2){1'b0}}};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_amplitude();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return CFG_W'($urandom_range(0, 65535));
            default: return $urandom_range(0, 32'h7FFF_FFFF);
        endcase
    endfunction

    task automatic program_random();
        program_rotator(pick_phase_reg(), pick_phase_reg(), pick_phase_reg(),
                        pick_amplitude(), $urandom());
    endtask

    // random words in bursts with random gaps when gaps are enabled
    task automatic run_traffic(input int words);
        for (int n = 0; n < words; n++) begin
            send_word(pick_sample(), pick_sample());
            if (src_gaps && burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end else if (burst_left > 0) begin
                burst_left--;
            end
        end
    endtask

    // registers at reset: phase zero, output is input scaled by full scale
    task automatic test_reset_phase();
        sink_mode = SINK_PATTERN;
        send_word(FULL_POS, FULL_POS);
        send_word(FULL_NEG, FULL_NEG);
        send_word(FULL_NEG, FULL_POS);
        send_word(FULL_POS, FULL_NEG);
        send_word('0, '0);
        send_word(SMP_W'(1), -SMP_W'(1));
        wait_drain();
    endtask

    // eighth-turn offset with quarter-turn steps walks every quadrant and saturates
    task automatic test_offset_rotation();
        program_rotator(32'h4000_0000, 32'h2000_0000, '0, '0, '0);
        send_word(FULL_POS, FULL_POS);
        send_word(FULL_POS, FULL_POS);
        send_word(FULL_NEG, FULL_NEG);
        send_word(FULL_POS, FULL_NEG);
        send_word(FULL_NEG, FULL_POS);
        wait_drain();
        program_rotator('1, '1, '1, '0, '0);
        send_word(FULL_POS, FULL_NEG);
        send_word(FULL_NEG, FULL_NEG);
        wait_drain();
    endtask

    // undecoded indexes are dropped, jitter enable keeps only bit 0
    task automatic test_register_decode();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, 32'h1234_5679);
        write_reg(REG_JITTER_ENABLE, 32'hFFFF_FFFE);
        cfg_we <= 1'b0;
        send_word(FULL_POS, '0);
        send_word('0, FULL_NEG);
        wait_drain();
    endtask

    // jitter at half-turn peak, then with the amplitude above half a turn
    task automatic test_jitter_mode();
        program_rotator(32'h0123_4567, 32'h4000_0000, 32'h4000_0000, 32'h8000_0000, 32'h3);
        repeat (5)
            send_word(FULL_POS, FULL_NEG);
        wait_drain();
        write_reg(REG_JITTER_AMP, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_word(FULL_NEG, FULL_NEG);
        send_word(FULL_POS, FULL_POS);
        send_word(FULL_NEG, FULL_POS);
        wait_drain();
    endtask

    // random settings per phase, extremes first, random idling on both sides
    task automatic test_random_traffic();
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                program_rotator('1, '1, '1, 32'h8000_0000, '0);
            else if (ph == 1)
                program_rotator('1, '1, '1, 32'h8000_0000, '1);
            else if (ph == 2)
                program_rotator('0, '0, '0, '0, 32'h1);
            else
                program_random();
            case ($urandom_range(0, 2))
                0: sink_mode = SINK_OPEN;
                1: sink_mode = SINK_PATTERN;
                default: sink_mode = SINK_RANDOM;
            endcase
            src_gaps   = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 24);
            run_traffic($urandom_range(80, 120));
            wait_drain();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_long_backpressure();
        program_random();
        src_gaps  = 1'b0;
        sink_mode = SINK_HOLD;
        run_traffic(100);
        wait_drain();
        sink_mode = SINK_RANDOM;
    endtask

    // receiver stall generator
    always @(posedge clk) begin
        if (sink_mode != SINK_HOLD)
            hold_count <= 0;
        else if (hold_count < LONG_HOLD)
            hold_count <= hold_count + 1;
        case (sink_mode)
            SINK_OPEN:
                out_stall <= 1'b0;
            SINK_PATTERN:
            begin
                out_stall     <= stall_pattern[0];
                stall_pattern <= {stall_pattern[0], stall_pattern[PAT_W-1:1]};
            end
            SINK_RANDOM:
                out_stall <= ($urandom_range(0, 2) == 0);
            default:
                out_stall <= (hold_count < LONG_HOLD);
        endcase
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_iq.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing expected: i=%0d q=%0d",
                                        results_seen, out_i, out_q));
            end else begin
                oldest_iq = pending_iq.pop_front();
                if (out_i !== oldest_iq.i)
                    flag_mismatch($sformatf("result %0d out_i=%0d expected %0d",
                                            results_seen, out_i, oldest_iq.i));
                if (out_q !== oldest_iq.q)
                    flag_mismatch($sformatf("result %0d out_q=%0d expected %0d",
                                            results_seen, out_q, oldest_iq.q));
            end
        end
    end

    // watchdog: too many cycles without any handshake ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("carrier_offset_rotator regression: fail");
        $finish;
    end

    // test sequence
    initial begin
        for (int k = 0; k <= TAB_N; k++)
            sine_rom[k] = taylor_sine(k);
        freq_step_m     = '0;
        phase_offset_m  = '0;
        jitter_step_m   = '0;
        jitter_amp_m    = '0;
        jitter_on_m     = 1'b0;
        carrier_phase_m = '0;
        jitter_phase_m  = '0;
        held_phase_m    = '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_phase();
        test_offset_rotation();
        test_register_decode();
        test_jitter_mode();
        test_random_traffic();
        test_long_backpressure();

        repeat (DRAIN_MARGIN)
            @(posedge clk);
        if (pending_iq.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", pending_iq.size()));
        if (mismatch_count == 0)
            $display("carrier_offset_rotator regression: pass");
        else
            $display("carrier_offset_rotator regression: fail");
        $finish;
    end

endmodule
